>>> hw/rtl/upx_pkg.sv
// upx_pkg: types, constants and register indexes of the 10-bit pixel unpacker
// depends on nothing; used by the stream interface and the top level
package upx_pkg;

  // default parameter values
  localparam int WORD_BITS_DEF  = 10;
  localparam int SYNC_WORDS_DEF = 2;
  localparam int MAX_WIDTH_DEF  = 4096;

  // lines per frame are clamped to this value
  localparam int MAX_LINES  = 4096;
  localparam int LINE_NUM_W = 12;

  // configuration port
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(320);
  localparam logic [CFG_W-1:0] LINE_COUNT_RST = CFG_W'(256);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } upx_in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
    logic       frame_end;
  } upx_out_t;

endpackage

>>> hw/rtl/upx_stream_if.sv
// upx_stream_if: valid/ready stream channel with a typed payload
// depends on upx_pkg for the default payload type
interface upx_stream_if
  import upx_pkg::*;
#(
  parameter type payload_t = upx_in_t
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> hw/rtl/unpack_10bit_pixel_stream.sv
// unpack_10bit_pixel_stream: top level of the packed pixel stream unpacker
// depends on upx_pkg and upx_stream_if
//
// Usage:
//   byte_i carries one raw camera byte per beat plus a frame_start flag that
//   marks the first byte of a frame. pix_o carries one 8-bit pixel per beat
//   (the top 8 bits of each WORD_BITS-bit word) with line_end and frame_end.
//   The cfg_* write channel sets line_width (index 0) and line_count (index 1);
//   it is always ready and should only be written while no beat is in flight.
//   Sync words at the head of each line are dropped. Bytes outside a frame
//   (before frame_start, after the frame_end pixel) give no output.
// Timing:
//   one byte beat is accepted every cycle while byte_i.ready is high; the byte
//   that completes a word loads its pixel into the output register (the skid
//   entry if pix_o stalls). The work per byte is one pass of the bit
//   accumulator and the word/line counters between state and output registers.
//   A two-entry output buffer (output register plus skid) keeps byte_i ready
//   while one pixel waits; byte_i.ready drops only when both are full.
// Reset:
//   rst_ni clears the accumulator and counters, empties the output buffer,
//   sets line_width 320, line_count 256 and waits for a frame start.
module unpack_10bit_pixel_stream
  import upx_pkg::*;
#(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int SYNC_WORDS = SYNC_WORDS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  upx_stream_if.sink            byte_i,
  upx_stream_if.source          pix_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int STORE_W = WORD_BITS - 1;
  localparam int ACC_W   = STORE_W + 8;
  localparam int HELD_W  = $clog2(WORD_BITS);
  localparam int BITS_W  = $clog2(ACC_W + 1);
  localparam int WIL_W   = $clog2(SYNC_WORDS + MAX_WIDTH + 1);
  localparam int CNT_W   = LINE_NUM_W + 2;

  // configuration
  logic [CFG_W-1:0] line_width_q, line_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      line_count_q <= LINE_COUNT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_LINE_WIDTH) begin
        line_width_q <= cfg_data_i[CFG_W-1:0];
      end else if (cfg_index_i == REG_LINE_COUNT) begin
        line_count_q <= cfg_data_i[CFG_W-1:0];
      end
    end
  end

  // clamped register values
  logic [WIL_W-1:0] eff_width;
  logic [CNT_W-1:0] eff_count;

  always_comb begin
    if (line_width_q == '0) begin
      eff_width = WIL_W'(1);
    end else if (32'(line_width_q) > MAX_WIDTH) begin
      eff_width = WIL_W'(MAX_WIDTH);
    end else begin
      eff_width = WIL_W'(line_width_q);
    end
    if (line_count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(line_count_q) > MAX_LINES) begin
      eff_count = CNT_W'(MAX_LINES);
    end else begin
      eff_count = CNT_W'(line_count_q);
    end
  end

  // unpack state
  logic [STORE_W-1:0]    bit_store_q, bit_store_d;
  logic [HELD_W-1:0]     bits_held_q, bits_held_d;
  logic [WIL_W-1:0]      word_in_line_q, word_in_line_d;
  logic [LINE_NUM_W-1:0] line_number_q, line_number_d;
  logic                  frame_active_q, frame_active_d;

  // output buffer
  upx_out_t out_q, out_d, skid_q, skid_d;
  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic     in_fire, out_fire, has_result;
  upx_out_t result;

  assign byte_i.ready  = !skid_valid_q;
  assign in_fire       = byte_i.valid && byte_i.ready;
  assign out_fire      = out_valid_q && pix_o.ready;
  assign pix_o.valid   = out_valid_q;
  assign pix_o.payload = out_q;

  always_comb begin
    logic [STORE_W-1:0]    store;
    logic [HELD_W-1:0]     held;
    logic [WIL_W-1:0]      wil;
    logic [LINE_NUM_W-1:0] lnum;
    logic                  active;
    logic [ACC_W-1:0]      acc;
    logic [BITS_W-1:0]     bits, rem;
    logic [WORD_BITS-1:0]  word;

    store  = bit_store_q;
    held   = bits_held_q;
    wil    = word_in_line_q;
    lnum   = line_number_q;
    active = frame_active_q;

    has_result = 1'b0;
    result     = '0;

    if (byte_i.payload.frame_start) begin
      store  = '0;
      held   = '0;
      wil    = '0;
      lnum   = '0;
      active = 1'b1;
    end

    acc  = {store, byte_i.payload.data_byte};
    bits = BITS_W'(held) + BITS_W'(8);
    rem  = bits - BITS_W'(WORD_BITS);
    word = WORD_BITS'(acc >> rem);

    if (active) begin
      if (32'(bits) < WORD_BITS) begin
        store = STORE_W'(acc);
        held  = HELD_W'(bits);
      end else begin
        store = STORE_W'(acc) & ~({STORE_W{1'b1}} << rem);
        held  = HELD_W'(rem);
        if (32'(wil) < SYNC_WORDS) begin
          wil = wil + WIL_W'(1);
        end else begin
          has_result   = 1'b1;
          result.pixel = word[WORD_BITS-1 -: 8];
          // index at or past the line end closes the line
          if ({1'b0, wil} + (WIL_W + 1)'(1) >=
              (WIL_W + 1)'(SYNC_WORDS) + {1'b0, eff_width}) begin
            result.line_end = 1'b1;
            wil             = '0;
            if (CNT_W'(lnum) + CNT_W'(1) >= eff_count) begin
              result.frame_end = 1'b1;
              lnum             = '0;
              active           = 1'b0;
            end else begin
              lnum = lnum + LINE_NUM_W'(1);
            end
          end else begin
            wil = wil + WIL_W'(1);
          end
        end
      end
    end

    bit_store_d    = store;
    bits_held_d    = held;
    word_in_line_d = wil;
    line_number_d  = lnum;
    frame_active_d = active;
  end

  // two-entry output buffer
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = in_fire && has_result;
      if (in_fire && has_result) begin
        out_d = result;
      end
    end else if (in_fire && has_result) begin
      // receiver stalled: park the new pixel
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_store_q    <= '0;
      bits_held_q    <= '0;
      word_in_line_q <= '0;
      line_number_q  <= '0;
      frame_active_q <= 1'b0;
      out_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        bit_store_q    <= bit_store_d;
        bits_held_q    <= bits_held_d;
        word_in_line_q <= word_in_line_d;
        line_number_q  <= line_number_d;
        frame_active_q <= frame_active_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule
